// ===== hdl/yhsbc_pkg.sv =====
`default_nettype none

package yhsbc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegCosCoef      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSinCoef      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSatGain      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegContrastGain = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBrightness   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRangeMode    = 3'd5;

  localparam logic signed [13:0] CosReset      = 14'sd4096;
  localparam logic signed [13:0] SinReset      = 14'sd0;
  localparam logic [12:0]        SatReset      = 13'd512;
  localparam logic [12:0]        ContrastReset = 13'd512;
  localparam logic signed [8:0]  BrightReset   = 9'sd0;

  // Clamp limits, as wide as the widest value that reaches the clamp.
  localparam int unsigned ClampW = 19;
  localparam logic signed [ClampW-1:0] FullLo   = 19'sd0;
  localparam logic signed [ClampW-1:0] FullHi   = 19'sd255;
  localparam logic signed [ClampW-1:0] LumaLo   = 19'sd15;
  localparam logic signed [ClampW-1:0] LumaHi   = 19'sd235;
  localparam logic signed [ClampW-1:0] ChromaLo = 19'sd16;
  localparam logic signed [ClampW-1:0] ChromaHi = 19'sd240;

  function automatic logic [7:0] clamp8(input logic signed [ClampW-1:0] x,
                                        input logic signed [ClampW-1:0] lo,
                                        input logic signed [ClampW-1:0] hi);
    logic signed [ClampW-1:0] r;
    r = x;
    if (x < lo) r = lo;
    if (x > hi) r = hi;
    return r[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/yuv_hue_sat_bright_contrast_unit.sv =====
// YUV processing amplifier for a 4:2:2 stream, one macropixel per transfer.
// Input stream (s_axis): tdata carries luma_a, luma_b, cb_in, cr_in. Output
// stream (m_axis): tdata carries luma_a_out, luma_b_out, cb_out, cr_out.
// Luma gets contrast and brightness; chroma gets hue rotation and saturation;
// every sample is clamped to the range that range_mode picks.
// The user must write registers through cfg_we_i/cfg_idx_i/cfg_data_i only
// while the stream is idle; the block does not enforce this. Indexes past
// the list are ignored. A result passes the registers of stages 1 to 4, the
// last of which drives m_axis. Throughput: one macropixel per cycle unless
// m_axis stalls; four register stages (hue products, rotation sum and shift,
// saturation product, shift and clamp) each take an item every cycle, so
// the limit is the slowest stage, one multiply deep.
// When m_axis_tready_i is low, the output register holds its item and the
// stages behind it fill up; bubbles in between are still filled, and
// s_axis_tready_o drops only once every stage holds an item.
// Reset empties the pipeline and returns the registers to unity gain, zero
// hue, zero brightness and full-range clamping.
`default_nettype none

module yuv_hue_sat_bright_contrast_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [yhsbc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [yhsbc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [7:0] luma_a, [15:8] luma_b, [23:16] cb_in, [31:24] cr_in
  input  wire logic [31:0]                      s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [7:0] luma_a_out, [15:8] luma_b_out, [23:16] cb_out, [31:24] cr_out
  output logic [31:0]                           m_axis_tdata_o
);

  // Configuration registers.
  logic signed [13:0] cos_q, sin_q;
  logic [12:0]        sat_q, cont_q;
  logic signed [8:0]  bright_q;
  logic               mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q    <= yhsbc_pkg::CosReset;
      sin_q    <= yhsbc_pkg::SinReset;
      sat_q    <= yhsbc_pkg::SatReset;
      cont_q   <= yhsbc_pkg::ContrastReset;
      bright_q <= yhsbc_pkg::BrightReset;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        yhsbc_pkg::RegCosCoef:      cos_q    <= $signed(cfg_data_i[13:0]);
        yhsbc_pkg::RegSinCoef:      sin_q    <= $signed(cfg_data_i[13:0]);
        yhsbc_pkg::RegSatGain:      sat_q    <= cfg_data_i[12:0];
        yhsbc_pkg::RegContrastGain: cont_q   <= cfg_data_i[12:0];
        yhsbc_pkg::RegBrightness:   bright_q <= $signed(cfg_data_i[8:0]);
        yhsbc_pkg::RegRangeMode:    mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its item moves on.
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, eno;

  assign eno = !vo_q || m_axis_tready_i;
  assign en3 = !v3_q || eno;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;
  assign m_axis_tvalid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  // Stage 1: center the samples and form the hue and contrast products.
  logic signed [9:0]  u_s, v_s, ya_s, yb_s;
  logic signed [13:0] cont_s;
  logic signed [23:0] ucos_d, vsin_d, vcos_d, usin_d, pya_d, pyb_d;
  logic signed [23:0] ucos_q, vsin_q, vcos_q, usin_q, pya_q, pyb_q;

  always_comb begin
    ya_s   = $signed({2'b00, s_axis_tdata_i[7:0]})   - 10'sd16;
    yb_s   = $signed({2'b00, s_axis_tdata_i[15:8]})  - 10'sd16;
    u_s    = $signed({2'b00, s_axis_tdata_i[23:16]}) - 10'sd128;
    v_s    = $signed({2'b00, s_axis_tdata_i[31:24]}) - 10'sd128;
    cont_s = $signed({1'b0, cont_q});
    ucos_d = u_s * cos_q;
    vsin_d = v_s * sin_q;
    vcos_d = v_s * cos_q;
    usin_d = u_s * sin_q;
    pya_d  = ya_s * cont_s;
    pyb_d  = yb_s * cont_s;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ucos_q <= ucos_d;
      vsin_q <= vsin_d;
      vcos_q <= vcos_d;
      usin_q <= usin_d;
      pya_q  <= pya_d;
      pyb_q  <= pyb_d;
    end
  end

  // Stage 2: finish the rotation with a floor shift by 12; finish luma.
  logic signed [24:0] su_s, sv_s;
  logic signed [15:0] bofs_s;
  logic signed [12:0] ux_d, vx_d, ux_q, vx_q;
  logic signed [15:0] ya_d, yb_d, ya_q, yb_q;

  always_comb begin
    su_s   = 25'(ucos_q) + 25'(vsin_q);
    sv_s   = 25'(vcos_q) - 25'(usin_q);
    ux_d   = su_s[24:12];
    vx_d   = sv_s[24:12];
    bofs_s = 16'(bright_q) + 16'sd16;
    ya_d   = 16'($signed(pya_q[23:9])) + bofs_s;
    yb_d   = 16'($signed(pyb_q[23:9])) + bofs_s;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      ux_q <= ux_d;
      vx_q <= vx_d;
      ya_q <= ya_d;
      yb_q <= yb_d;
    end
  end

  // Stage 3: saturation products; hold luma alongside.
  logic signed [13:0] sat_s;
  logic signed [26:0] pu_d, pv_d, pu_q, pv_q;
  logic signed [15:0] ya3_q, yb3_q;

  always_comb begin
    sat_s = $signed({1'b0, sat_q});
    pu_d  = ux_q * sat_s;
    pv_d  = vx_q * sat_s;
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pu_q  <= pu_d;
      pv_q  <= pv_d;
      ya3_q <= ya_q;
      yb3_q <= yb_q;
    end
  end

  // Stage 4: floor shift by 9, re-add 128, clamp per range mode.
  logic signed [yhsbc_pkg::ClampW-1:0] cu_s, cv_s, la_s, lb_s;
  logic signed [yhsbc_pkg::ClampW-1:0] ylo, yhi, clo, chi;
  logic [31:0] out_d, out_q;

  always_comb begin
    cu_s = yhsbc_pkg::ClampW'($signed(pu_q[26:9])) + 19'sd128;
    cv_s = yhsbc_pkg::ClampW'($signed(pv_q[26:9])) + 19'sd128;
    la_s = yhsbc_pkg::ClampW'(ya3_q);
    lb_s = yhsbc_pkg::ClampW'(yb3_q);
    ylo  = mode_q ? yhsbc_pkg::LumaLo   : yhsbc_pkg::FullLo;
    yhi  = mode_q ? yhsbc_pkg::LumaHi   : yhsbc_pkg::FullHi;
    clo  = mode_q ? yhsbc_pkg::ChromaLo : yhsbc_pkg::FullLo;
    chi  = mode_q ? yhsbc_pkg::ChromaHi : yhsbc_pkg::FullHi;
    out_d[7:0]   = yhsbc_pkg::clamp8(la_s, ylo, yhi);
    out_d[15:8]  = yhsbc_pkg::clamp8(lb_s, ylo, yhi);
    out_d[23:16] = yhsbc_pkg::clamp8(cu_s, clo, chi);
    out_d[31:24] = yhsbc_pkg::clamp8(cv_s, clo, chi);
  end

  always_ff @(posedge clk_i) begin
    if (eno) out_q <= out_d;
  end

  assign m_axis_tdata_o = out_q;

endmodule

`default_nettype wire

// ===== sim/yuv_hue_sat_bright_contrast_unit_test.sv =====
`default_nettype none

module yuv_hue_sat_bright_contrast_unit_test;

  localparam logic [yhsbc_pkg::CfgIdxW-1:0] CfgIdxSpare0 = 3'd6;
  localparam logic [yhsbc_pkg::CfgIdxW-1:0] CfgIdxSpare1 = 3'd7;

  localparam int unsigned PipeDepth        = 4;
  localparam int unsigned NumPhases        = 10;
  localparam int unsigned RandPerPhase     = 140;
  localparam int unsigned LongHoldCycles   = 300;
  localparam int unsigned HoldAfterResults = 200;

  typedef struct packed {
    logic [13:0] hue_cos;
    logic [13:0] hue_sin;
    logic [12:0] sat;
    logic [12:0] contrast;
    logic [8:0]  bright;
    logic        mode;
  } amp_settings_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic [31:0] want;
  } pixel_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [yhsbc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [yhsbc_pkg::CfgDataW-1:0] cfg_data_i;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  // [7:0] luma_a, [15:8] luma_b, [23:16] cb_in, [31:24] cr_in
  logic [31:0]                    s_axis_tdata_i;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  // [7:0] luma_a_out, [15:8] luma_b_out, [23:16] cb_out, [31:24] cr_out
  logic [31:0]                    m_axis_tdata_o;

  yuv_hue_sat_bright_contrast_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Register image of the block, updated on every write.
  logic [13:0] amp_cos;
  logic [13:0] amp_sin;
  logic [12:0] amp_sat;
  logic [12:0] amp_contrast;
  logic [8:0]  amp_bright;
  logic        amp_mode;

  logic [31:0] expected_macropixels [$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;

  // Travels with the offered transfer: use a typed-in result instead of the predictor.
  logic        row_known;
  logic [31:0] row_expect;
  logic        send_steady;

  string field_names [4] = '{"luma_a_out", "luma_b_out", "cb_out", "cr_out"};

  // Unity settings pass every sample through unchanged.
  pixel_row_t identity_rows [12] = '{
    '{32'h0000_0000, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'h8080_8080, 32'h8080_8080},
    '{32'h8080_1010, 32'h8080_1010},
    '{32'h00FF_00FF, 32'h00FF_00FF},
    '{32'hFF00_FF00, 32'hFF00_FF00},
    '{32'h817F_0FEB, 32'h817F_0FEB},
    '{32'hF010_EB0F, 32'hF010_EB0F},
    '{32'h55AA_55AA, 32'h55AA_55AA},
    '{32'hAA55_AA55, 32'hAA55_AA55},
    '{32'h7F81_01FE, 32'h7F81_01FE},
    '{32'h01FE_7F80, 32'h01FE_7F80}
  };

  function automatic logic [7:0] clip_sample(longint x, longint lo, longint hi);
    return (x < lo) ? 8'(lo) : ((x > hi) ? 8'(hi) : 8'(x));
  endfunction

  function automatic logic [7:0] adjust_luma(logic [7:0] s);
    longint y;
    y = (longint'(amp_contrast) * (longint'(s) - 16)) >>> 9;
    y = y + longint'($signed(amp_bright)) + 16;
    if (amp_mode)
      return clip_sample(y, longint'(yhsbc_pkg::LumaLo), longint'(yhsbc_pkg::LumaHi));
    return clip_sample(y, longint'(yhsbc_pkg::FullLo), longint'(yhsbc_pkg::FullHi));
  endfunction

  function automatic logic [7:0] scale_chroma(longint c);
    longint r;
    r = ((c * longint'(amp_sat)) >>> 9) + 128;
    if (amp_mode)
      return clip_sample(r, longint'(yhsbc_pkg::ChromaLo), longint'(yhsbc_pkg::ChromaHi));
    return clip_sample(r, longint'(yhsbc_pkg::FullLo), longint'(yhsbc_pkg::FullHi));
  endfunction

  function automatic logic [31:0] predict_macropixel(logic [31:0] d);
    longint cs, sn, u, v, ux, vx;
    cs = longint'($signed(amp_cos));
    sn = longint'($signed(amp_sin));
    u  = longint'(d[23:16]) - 128;
    v  = longint'(d[31:24]) - 128;
    ux = (u * cs + v * sn) >>> 12;
    vx = (v * cs - u * sn) >>> 12;
    return {scale_chroma(vx), scale_chroma(ux), adjust_luma(d[15:8]), adjust_luma(d[7:0])};
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h10;
      3: return 8'h80;
      4: return 8'h0F;
      5: return 8'hEB;
      6: return 8'hF0;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_macropixel();
    if ($urandom_range(0, 4) == 0)
      return {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
    return $urandom;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic amp_settings_t phase_settings(int unsigned p);
    amp_settings_t s;
    case (p)
      0: s = '{14'h2000, 14'h1FFF, 13'h1FFF, 13'h1FFF, 9'h100, 1'b1};
      1: s = '{14'h1FFF, 14'h2000, 13'h0000, 13'h0000, 9'h0FF, 1'b0};
      2: s = '{14'h3000, 14'h1000, 13'd512, 13'd512, 9'h101, 1'b1};
      3: s = '{14'h0000, 14'h3000, 13'd1024, 13'd256, 9'd40, 1'b0};
      default: begin
        // Hue pairs in range half the time, gains in two of three; the rest raw bits.
        if ($urandom_range(0, 1) == 0) begin
          s.hue_cos = 14'($urandom);
          s.hue_sin = 14'($urandom);
        end else begin
          s.hue_cos = 14'(int'($urandom_range(0, 8192)) - 4096);
          s.hue_sin = 14'(int'($urandom_range(0, 8192)) - 4096);
        end
        s.sat      = ($urandom_range(0, 2) == 0) ? 13'($urandom) : 13'($urandom_range(0, 1536));
        s.contrast = ($urandom_range(0, 2) == 0) ? 13'($urandom) : 13'($urandom_range(0, 1536));
        s.bright   = 9'($urandom);
        s.mode     = 1'($urandom);
      end
    endcase
    return s;
  endfunction

  task automatic write_reg(input logic [yhsbc_pkg::CfgIdxW-1:0] idx,
                           input logic [yhsbc_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      yhsbc_pkg::RegCosCoef:      amp_cos      = val;
      yhsbc_pkg::RegSinCoef:      amp_sin      = val;
      yhsbc_pkg::RegSatGain:      amp_sat      = val[12:0];
      yhsbc_pkg::RegContrastGain: amp_contrast = val[12:0];
      yhsbc_pkg::RegBrightness:   amp_bright   = val[8:0];
      yhsbc_pkg::RegRangeMode:    amp_mode     = val[0];
      default: ;
    endcase
  endtask

  task automatic program_amp(input amp_settings_t s);
    write_reg(yhsbc_pkg::RegCosCoef, s.hue_cos);
    write_reg(CfgIdxSpare0, 14'($urandom));
    write_reg(yhsbc_pkg::RegSinCoef, s.hue_sin);
    write_reg(yhsbc_pkg::RegSatGain, yhsbc_pkg::CfgDataW'(s.sat));
    write_reg(yhsbc_pkg::RegContrastGain, yhsbc_pkg::CfgDataW'(s.contrast));
    write_reg(yhsbc_pkg::RegBrightness, yhsbc_pkg::CfgDataW'(s.bright));
    write_reg(yhsbc_pkg::RegRangeMode, yhsbc_pkg::CfgDataW'(s.mode));
    write_reg(CfgIdxSpare1, 14'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every result is back and the pipeline has drained; ends on a falling edge.
  task automatic drain_pipeline();
    while (expected_macropixels.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Called on a falling edge; returns on the falling edge after the transfer.
  task automatic offer_macropixel(input logic [31:0] data, input logic known,
                                  input logic [31:0] expect_word);
    int unsigned gap;
    gap = send_steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    row_known       <= known;
    row_expect      <= expect_word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("yuv_hue_sat_bright_contrast_unit_test: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin : scoreboard
    logic [31:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_macropixels.push_back(row_known ? row_expect
                                                 : predict_macropixel(s_axis_tdata_i));
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        if (expected_macropixels.size() == 0) begin
          $error("unexpected transfer on m_axis: %h", m_axis_tdata_o);
          mismatch_count++;
        end else begin
          want = expected_macropixels.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (m_axis_tdata_o[8*i +: 8] !== want[8*i +: 8]) begin
              $error("%s: expected %0d, got %0d", field_names[i], want[8*i +: 8],
                     m_axis_tdata_o[8*i +: 8]);
              mismatch_count++;
            end
          end
        end
      end
    end
  end

  initial begin : result_side
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned r;
    logic        long_hold_done;
    stall_left = 0;
    free_left = 0;
    long_hold_done = 1'b0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      // Hold off once for a long stretch so the pipeline backs up into s_axis.
      if (!long_hold_done && results_seen >= HoldAfterResults) begin
        long_hold_done = 1'b1;
        stall_left = LongHoldCycles;
      end
      if (stall_left != 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if (free_left != 0) begin
        m_axis_tready_i <= 1'b1;
        free_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) free_left = $urandom_range(20, 120);
        else if (r < 16) stall_left = $urandom_range(8, 40);
        m_axis_tready_i <= (r < 10) || (r >= 55);
      end
    end
  end

  initial begin : source_side
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = yhsbc_pkg::RegCosCoef;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    row_known       = 1'b0;
    row_expect      = '0;
    send_steady     = 1'b0;
    amp_cos         = yhsbc_pkg::CosReset;
    amp_sin         = yhsbc_pkg::SinReset;
    amp_sat         = yhsbc_pkg::SatReset;
    amp_contrast    = yhsbc_pkg::ContrastReset;
    amp_bright      = yhsbc_pkg::BrightReset;
    amp_mode        = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: unity gains, no hue turn, full range.
    foreach (identity_rows[i])
      offer_macropixel(identity_rows[i].pixel, 1'b1, identity_rows[i].want);
    s_axis_tvalid_i <= 1'b0;

    for (int unsigned p = 0; p < NumPhases; p++) begin
      drain_pipeline();
      program_amp(phase_settings(p));
      send_steady = (p % 3 == 2);
      foreach (identity_rows[i])
        offer_macropixel(identity_rows[i].pixel, 1'b0, '0);
      repeat (RandPerPhase)
        offer_macropixel(random_macropixel(), 1'b0, '0);
      s_axis_tvalid_i <= 1'b0;
    end

    drain_pipeline();
    if (mismatch_count == 0 && expected_macropixels.size() == 0)
      $display("yuv_hue_sat_bright_contrast_unit_test: done, clean");
    else
      $display("yuv_hue_sat_bright_contrast_unit_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
